// ===== hw/rtl/bxt_pkg.sv =====
`default_nettype none
package bxt_pkg;
    localparam int KEY_W     = 31;
    localparam int LEVELS    = KEY_W;
    localparam int MAX_KEYS  = 1024;
    localparam int POOL_SIZE = MAX_KEYS * LEVELS;
    localparam int NODE_W    = $clog2(POOL_SIZE);
    localparam int LVL_W     = $clog2(LEVELS);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MAX    = 2'd1;
    localparam logic [1:0] OP_MIN    = 2'd2;

    localparam logic [NODE_W-1:0] NO_CHILD  = '0;
    localparam logic [NODE_W-1:0] FULL_MARK = NODE_W'(POOL_SIZE - LEVELS);
    localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVELS - 1);
endpackage
`default_nettype wire

// ===== hw/rtl/bxt_cell.sv =====
`default_nettype none
module bxt_cell
    import bxt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_load,
    input  wire logic i_shift,
    input  wire logic i_load_key,
    input  wire logic i_key_prev,
    input  wire logic i_res_prev,
    output logic      o_key,
    output logic      o_res
);
    logic r_key;
    logic r_res;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_load_key;
            r_res <= 1'b0;
        end else if (i_shift) begin
            r_key <= i_key_prev;
            r_res <= i_res_prev;
        end
    end

    assign o_key = r_key;
    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== hw/rtl/binary_xor_trie.sv =====
`default_nettype none
// Channel | Direction | Handshake             | Payload
// in      | input     | i_in_valid/o_in_stall | i_operation, i_key_value
// out     | output    | o_out_valid/i_out_stall | o_partner_key, o_pool_full
//
// Every item passes through accept, 31 levels (one node memory read per
// level in a shared walker), and a step to move the result to the output.
// Key and result bits travel through a chain of 31 bit cells, one per level.
// Reset: root has no children, one node in use; no clearing pass.
// A stalled output holds the next item in its final cycle until taken.
module binary_xor_trie
    import bxt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [KEY_W-1:0]  i_key_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [KEY_W-1:0]       o_partner_key,
    output logic                   o_pool_full
);
    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    logic [NODE_W-1:0] r_node;
    logic              r_fresh;
    logic              r_dead;
    logic              r_full;
    logic [LVL_W-1:0]  r_lvl;
    logic [NODE_W-1:0] r_used;
    logic [NODE_W-1:0] r_root_one;
    logic [NODE_W-1:0] r_root_zero;
    logic [2*NODE_W-1:0] r_rdata;
    logic              r_out_vld;
    logic [KEY_W-1:0]  r_out_key;
    logic              r_out_full;

    logic [2*NODE_W-1:0] mem [POOL_SIZE];

    logic [KEY_W-1:0] key_bits;
    logic [KEY_W-1:0] res_bits;

    logic              accept;
    logic              shift;
    logic              refuse;
    logic [NODE_W-1:0] view_one;
    logic [NODE_W-1:0] view_zero;
    logic              qb;
    logic              pref;
    logic [NODE_W-1:0] first;
    logic [NODE_W-1:0] second;
    logic [NODE_W-1:0] n_node;
    logic [NODE_W-1:0] wr_one;
    logic [NODE_W-1:0] wr_zero;
    logic              alloc;
    logic              res_bit;
    logic              n_dead;
    logic              out_take;
    logic              out_load;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign shift    = (r_state == S_WALK);
    assign refuse   = (i_operation == OP_INSERT) && (r_used > FULL_MARK);
    assign qb       = key_bits[KEY_W-1];
    assign out_take = r_out_vld && !i_out_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    for (genvar k = 0; k < KEY_W; k++) begin : g_cell
        bxt_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (accept),
            .i_shift    (shift),
            .i_load_key (i_key_value[k]),
            .i_key_prev ((k == 0) ? 1'b0 : key_bits[(k == 0) ? 0 : k-1]),
            .i_res_prev ((k == 0) ? res_bit : res_bits[(k == 0) ? 0 : k-1]),
            .o_key      (key_bits[k]),
            .o_res      (res_bits[k])
        );
    end

    always_comb begin
        if (r_node == NO_CHILD) begin
            view_one  = r_root_one;
            view_zero = r_root_zero;
        end else if (r_fresh) begin
            view_one  = NO_CHILD;
            view_zero = NO_CHILD;
        end else begin
            view_one  = r_rdata[2*NODE_W-1:NODE_W];
            view_zero = r_rdata[NODE_W-1:0];
        end
        pref    = (r_op == OP_MAX) ? !qb : qb;
        first   = pref ? view_one : view_zero;
        second  = pref ? view_zero : view_one;
        n_node  = r_node;
        wr_one  = view_one;
        wr_zero = view_zero;
        alloc   = 1'b0;
        res_bit = 1'b0;
        n_dead  = r_dead;
        if (!r_dead) begin
            if (r_op == OP_INSERT) begin
                if (qb) begin
                    if (view_one == NO_CHILD) begin
                        alloc  = 1'b1;
                        wr_one = r_used;
                        n_node = r_used;
                    end else begin
                        n_node = view_one;
                    end
                end else begin
                    if (view_zero == NO_CHILD) begin
                        alloc   = 1'b1;
                        wr_zero = r_used;
                        n_node  = r_used;
                    end else begin
                        n_node = view_zero;
                    end
                end
            end else if (first != NO_CHILD) begin
                n_node  = first;
                res_bit = pref;
            end else if (second != NO_CHILD) begin
                n_node  = second;
                res_bit = !pref;
            end else begin
                n_dead = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_rdata <= mem[n_node];
            if (alloc && (r_node != NO_CHILD)) begin
                mem[r_node] <= {wr_one, wr_zero};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= NODE_W'(1);
            r_root_one  <= NO_CHILD;
            r_root_zero <= NO_CHILD;
            r_out_vld   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (alloc) begin
                        r_used <= r_used + NODE_W'(1);
                        if (r_node == NO_CHILD) begin
                            r_root_one  <= wr_one;
                            r_root_zero <= wr_zero;
                        end
                    end
                    if (r_lvl == LAST_LVL) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_node  <= NO_CHILD;
            r_fresh <= 1'b0;
            r_dead  <= refuse || (i_operation != OP_INSERT && i_operation != OP_MAX
                                  && i_operation != OP_MIN);
            r_full  <= refuse;
            r_lvl   <= '0;
        end else if (shift) begin
            r_node  <= n_node;
            r_fresh <= alloc;
            r_dead  <= n_dead;
            r_lvl   <= r_lvl + LVL_W'(1);
        end
        if (out_load) begin
            r_out_key  <= res_bits;
            r_out_full <= r_full;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_partner_key = r_out_key;
    assign o_pool_full   = r_out_full;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NODE_W'(POOL_SIZE))
        else $error("node pool overrun");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result without finished walk");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pool_full) |-> (o_partner_key == '0))
        else $error("refused insert with partner key");

    a_no_alloc_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift && r_full) |-> !alloc)
        else $error("allocation on refused insert");
endmodule
`default_nettype wire
